// ----- rtl/sst_pkg.sv -----
// Shared types and codes for the sorted set table.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package sst_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DUP      = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

endpackage

// ----- rtl/sst_if.sv -----
// Valid/ready channel interfaces for the sorted set table.
// Depends on nothing; the widths follow the fixed field widths.
`timescale 1ns / 1ps

interface sst_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface sst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ----- rtl/sst_ram.sv -----
// Simple dual-port value store: one write port, one registered read port.
// Depends on sst_pkg for the value width.
`timescale 1ns / 1ps

module sst_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic signed [sst_pkg::VALUE_W-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic signed [sst_pkg::VALUE_W-1:0] rdata
);
  import sst_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sorted_set_table_core.sv -----
// Top level of the sorted set table: sequencer, count register and result register.
// Depends on sst_pkg, sst_in_if, sst_out_if and sst_ram.
`timescale 1ns / 1ps
//
//  Channel  Dir  Beat contents              Accepted when
//  in_ch    in   op, value                  valid && ready
//  out_ch   out  status, entry_count        valid && ready
//
// Clear goes straight to the result. Lookup runs a linear search through the single read
// port of the store; a successful insert or delete then moves the tail through the single
// read port and single write port of the store.
// Reset empties the table at once; stored entries are never cleared.
// A new beat is taken while a finished result still waits on a stalled out_ch.

module sorted_set_table_core #(
  parameter int unsigned DEPTH = 64
) (
  input logic clk,
  input logic rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);
  import sst_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_SHFT = 5'b00100,
    S_FIN  = 5'b01000,
    S_RSLT = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      rv_r, rv_nxt;
  logic                      out_valid_r, out_valid_nxt;
  op_t                       op_r, op_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [AW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             rem_r, rem_nxt;
  logic [AW-1:0]             src_r, src_nxt;
  logic [AW-1:0]             dst_r, dst_nxt;
  logic                      up_r, up_nxt;
  status_t                   st_r, st_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic signed [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic                      srch_done, srch_hit, more;
  logic [CW-1:0]             srch_pos, cnt_m1, pos_p1;
  logic [CW+COUNT_W-1:0]     cnt_ext;

  sst_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  assign more    = (i_r < count_r);
  assign cnt_m1  = count_r - CW'(1);
  assign pos_p1  = srch_pos + CW'(1);
  assign cnt_ext = {{COUNT_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rv_nxt         = rv_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    up_nxt         = up_r;
    st_nxt         = st_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = dst_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = i_r[AW-1:0];
    srch_done      = 1'b0;
    srch_hit       = 1'b0;
    srch_pos       = count_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt  = op_t'(in_ch.op);
          key_nxt = in_ch.value;
          i_nxt   = '0;
          rv_nxt  = 1'b0;
          st_nxt  = ST_OK;
          unique case (op_t'(in_ch.op))
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RSLT;
            end
            OP_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_RSLT;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: begin
              state_nxt = S_SRCH;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (rv_r && !(ram_rdata < key_r)) begin
          srch_done = 1'b1;
          srch_pos  = CW'(j_r);
          srch_hit  = (ram_rdata == key_r);
        end else if (more) begin
          ram_re = 1'b1;
          rv_nxt = 1'b1;
          j_nxt  = i_r[AW-1:0];
          i_nxt  = i_r + CW'(1);
        end else begin
          srch_done = 1'b1;
        end

        if (srch_done) begin
          rv_nxt  = 1'b0;
          pos_nxt = srch_pos;
          unique case (op_r)
            OP_INSERT: begin
              if (srch_hit) begin
                st_nxt    = ST_DUP;
                state_nxt = S_RSLT;
              end else begin
                rem_nxt   = count_r - srch_pos;
                src_nxt   = cnt_m1[AW-1:0];
                up_nxt    = 1'b1;
                state_nxt = S_SHFT;
              end
            end
            OP_DELETE: begin
              if (srch_hit) begin
                rem_nxt   = cnt_m1 - srch_pos;
                src_nxt   = pos_p1[AW-1:0];
                up_nxt    = 1'b0;
                state_nxt = S_SHFT;
              end else begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_RSLT;
              end
            end
            default: begin
              st_nxt    = srch_hit ? ST_OK : ST_NOTFOUND;
              state_nxt = S_RSLT;
            end
          endcase
        end
      end

      S_SHFT: begin
        if (rv_r) begin
          ram_we = 1'b1;
        end
        if (rem_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_r;
          rv_nxt    = 1'b1;
          rem_nxt   = rem_r - CW'(1);
          dst_nxt   = up_r ? src_r + AW'(1) : src_r - AW'(1);
          src_nxt   = up_r ? src_r - AW'(1) : src_r + AW'(1);
        end else begin
          rv_nxt = 1'b0;
          if (!rv_r) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (op_r == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[AW-1:0];
          ram_wdata = key_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = cnt_m1;
        end
        state_nxt = S_RSLT;
      end

      S_RSLT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_count_nxt  = cnt_ext[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pos_r        <= pos_nxt;
    rem_r        <= rem_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    up_r         <= up_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// ----- rtl/sst_checker.sv -----
// Port-level checks for sorted_set_table_core and the bind that attaches them.
// Depends on sst_pkg and sorted_set_table_core.
`timescale 1ns / 1ps

module sst_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [6:0] out_entry_count
);
  import sst_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while an operation is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH > 127) || (out_entry_count <= DEPTH))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (DEPTH > 127) || (out_entry_count == DEPTH))
    else $error("full reported with a table that is not full");

endmodule

bind sorted_set_table_core sst_checker #(.DEPTH(DEPTH)) u_sst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count)
);

// ----- test/sst_table_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sorted set table. It keeps its own copy of the ordered table,
// predicts the reply to every accepted request beat and compares each result beat.
// Depends on sst_pkg.

module sst_table_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [sst_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [1:0]                  out_status,
  input  logic [sst_pkg::COUNT_W-1:0] out_entry_count,
  output int                          fail_count,
  output int                          pending,
  output int                          replies_checked,
  output int                          full_seen,
  output int                          dup_seen,
  output int                          miss_seen
);
  import sst_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
  } reply_t;

  logic signed [VALUE_W-1:0] table_vals [DEPTH];
  int unsigned               fill;
  reply_t                    reply_q [$];

  function automatic reply_t apply_table_op(op_t op, logic signed [VALUE_W-1:0] value);
    reply_t      r;
    int unsigned pos;
    int unsigned i;
    r.status = ST_OK;
    pos = 0;
    while (pos < fill && pos < DEPTH && table_vals[pos] < value) pos++;
    case (op)
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < fill && table_vals[pos] == value) begin
          r.status = ST_DUP;
        end else begin
          for (i = fill; i > pos; i--) table_vals[i] = table_vals[i - 1];
          table_vals[pos] = value;
          fill++;
        end
      end
      OP_DELETE: begin
        if (pos < fill && table_vals[pos] == value) begin
          for (i = pos; i + 1 < fill; i++) table_vals[i] = table_vals[i + 1];
          fill--;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_LOOKUP: begin
        if (!(pos < fill && table_vals[pos] == value)) r.status = ST_NOTFOUND;
      end
      default: begin
        fill = 0;
      end
    endcase
    r.entry_count = fill[COUNT_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count      = 0;
    pending         = 0;
    replies_checked = 0;
    full_seen       = 0;
    dup_seen        = 0;
    miss_seen       = 0;
    fill            = 0;
  end

  always @(posedge clk) begin
    reply_t want;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      fill = 0;
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          errs++;
          $display("%0t: result beat with no request waiting, expected none, %s %0d count %0d",
                   $time, "actual status", out_status, out_entry_count);
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_entry_count !== want.entry_count) begin
            errs++;
            $display("%0t: entry count mismatch, expected %0d, actual %0d",
                     $time, want.entry_count, out_entry_count);
          end
        end
        replies_checked <= replies_checked + 1;
        if (out_status == ST_FULL) full_seen <= full_seen + 1;
        if (out_status == ST_DUP) dup_seen <= dup_seen + 1;
        if (out_status == ST_NOTFOUND) miss_seen <= miss_seen + 1;
      end
      if (in_valid && in_ready) begin
        reply_q.push_back(apply_table_op(op_t'(in_op), in_value));
      end
    end
    fail_count <= fail_count + errs;
    pending    <= reply_q.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sorted set table testbench: clock, reset, request and result drivers,
// watchdog and verdict. Depends on sst_pkg, sst_in_if, sst_out_if,
// sorted_set_table_core and sst_table_checker.

module testbench;
  import sst_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int          ITEM_TARGET  = 1450;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          POOL_SPAN    = 80;
  localparam int          FILL_SPAN    = 70;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   sent = 0;
  int   stall_cycles = 0;
  int   fail_count;
  int   pending;
  int   replies_checked;
  int   full_seen;
  int   dup_seen;
  int   miss_seen;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sorted_set_table_core #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sst_table_checker #(.DEPTH(DEPTH)) table_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count),
    .fail_count      (fail_count),
    .pending         (pending),
    .replies_checked (replies_checked),
    .full_seen       (full_seen),
    .dup_seen        (dup_seen),
    .miss_seen       (miss_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic op_t choose_op(int mode, int roll);
    case (mode)
      0: return (roll < 85) ? OP_INSERT : (roll < 95) ? OP_LOOKUP : OP_DELETE;
      1: return (roll < 40) ? OP_INSERT : (roll < 70) ? OP_DELETE :
                (roll < 97) ? OP_LOOKUP : OP_CLEAR;
      2: return (roll < 20) ? OP_INSERT : (roll < 75) ? OP_DELETE : OP_LOOKUP;
      default: return (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE :
                      (roll < 95) ? OP_LOOKUP : OP_CLEAR;
    endcase
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int                        phase;
    int                        mode;
    int                        len;
    int                        roll;
    int                        i;
    int                        j;
    int                        t;
    int                        order [FILL_SPAN];
    logic signed [VALUE_W-1:0] base;
    logic signed [VALUE_W-1:0] value;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_INSERT;
    in_ch.value <= '0;
    no_idle      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_LOOKUP, 32'sd0);
    send_request(OP_DELETE, 32'sd5);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7FFF_FFFF);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh7FFF_FFFF);
    send_request(OP_LOOKUP, 32'sh8000_0000);
    send_request(OP_LOOKUP, 32'sh7FFF_FFFF);
    send_request(OP_LOOKUP, 32'sd2);
    send_request(OP_DELETE, -32'sd1);
    send_request(OP_DELETE, -32'sd1);
    send_request(OP_DELETE, 32'sh8000_0000);
    send_request(OP_DELETE, 32'sh7FFF_FFFF);
    send_request(OP_LOOKUP, 32'sh5555_5555);
    send_request(OP_INSERT, 32'sh5555_5555);
    send_request(OP_INSERT, 32'shAAAA_AAAA);
    send_request(OP_CLEAR, 32'sd12345);
    send_request(OP_LOOKUP, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_CLEAR, 32'shFFFF_FFFF);

    in_ch.valid <= 1'b0;
    wait_drained();

    phase = 0;
    while (sent < ITEM_TARGET) begin
      mode    = (phase == 0) ? 4 : $urandom_range(0, 4);
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: base = 32'sh8000_0000;
        1: base = 32'sh7FFF_FFFF - (POOL_SPAN - 1);
        2: base = -32'sd40;
        default: base = $urandom;
      endcase
      if ($urandom_range(0, 2) == 0) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      if (mode == 4) begin
        for (i = 0; i < FILL_SPAN; i++) order[i] = i;
        for (i = FILL_SPAN - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          t        = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        send_request(OP_CLEAR, $urandom);
        for (i = 0; i < FILL_SPAN; i++) send_request(OP_INSERT, base + order[i]);
        repeat (10) send_request(OP_LOOKUP, base + $urandom_range(0, POOL_SPAN - 1));
      end else begin
        len = $urandom_range(60, 160);
        if (len > ITEM_TARGET - sent) len = ITEM_TARGET - sent;
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (mode == 3 || $urandom_range(0, 19) == 0) begin
            value = $urandom;
          end else begin
            value = base + $urandom_range(0, POOL_SPAN - 1);
          end
          send_request(choose_op(mode, roll), value);
        end
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run sent %0d request beats over %0d random phases, %0d replies checked.",
             sent, phase, replies_checked);
    $display("Replies seen: %0d table full, %0d duplicate, %0d not found.",
             full_seen, dup_seen, miss_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
